FILE: src/prd_pkg.sv
// Package for the pulse rate detector.
// Holds the payload and queue types, register indexes, reset values and sizing constants.
// No dependencies.
package prd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TIME_W   = 16;
    localparam int SUM_W    = 16;
    localparam int MEAN_W   = 13;
    localparam int BPM_W    = 16;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;

    localparam int GROUP_LEN       = 10;
    localparam int GROUP_CNT_W     = 4;
    localparam int WINDOW_LEN_DEF  = 20;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [BPM_W-1:0]    BPM_DIVIDEND = 16'd60000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 12'd4095;

    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_SPAN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_MARGIN = 2'd2;

    localparam logic [CFG_W-1:0] BASELINE_OFFSET_RST  = 12'd1500;
    localparam logic [CFG_W-1:0] ACCEPT_SPAN_RST      = 12'd1000;
    localparam logic [CFG_W-1:0] THRESHOLD_MARGIN_RST = 12'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   time_ms;
    } in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] reading;
        logic                above_level;
        logic                bpm_valid;
        logic [BPM_W-1:0]    bpm;
    } out_t;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] min;
        logic [SAMPLE_W-1:0] max;
        logic [TIME_W-1:0]   time_ms;
    } job_t;

endpackage

FILE: src/pulse_rate_detector.sv
// Top level of the pulse rate detector.
// Joins the sample front end, the job queue and the result back end.
// Depends on prd_pkg, prd_front, prd_queue and prd_back.
//
//   Channel   Ports                       Carries
//   input     s_valid, s_ready, s_data    one sample with its millisecond tick
//   result    m_valid, m_ready, m_data    one result for every tenth sample
//   config    cfg_we, cfg_index, cfg_wdata  register writes, no read-back
//
// The front end takes a sample in every cycle while the queue has room.
// The back end takes a group through accept, window, edge and output states,
// adding a divider state for a beat rate, with one quotient bit per cycle.
// Reset is synchronous and active low; it restores the register defaults.
// A stalled result holds the back end; the queue keeps the front running until it fills.
module pulse_rate_detector #(
    parameter int WINDOW_LEN  = prd_pkg::WINDOW_LEN_DEF,
    parameter int QUEUE_DEPTH = prd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [prd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  prd_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output prd_pkg::out_t                 m_data
);

    logic          push_valid, push_ready;
    prd_pkg::job_t push_data;
    logic          pop_valid, pop_ready;
    prd_pkg::job_t pop_data;

    prd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_data  (push_data)
    );

    prd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    prd_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: src/prd_front.sv
// Front end of the pulse rate detector: gathers groups of ten samples.
// Keeps the running sum, minimum and maximum and queues one job per group.
// Depends on prd_pkg.
module prd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  prd_pkg::in_t  s_data,
    output logic          job_valid,
    input  logic          job_ready,
    output prd_pkg::job_t job_data
);

    logic [prd_pkg::GROUP_CNT_W-1:0] count_reg, count_next;
    logic [prd_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [prd_pkg::SAMPLE_W-1:0]    min_reg, min_next;
    logic [prd_pkg::SAMPLE_W-1:0]    max_reg, max_next;
    logic [prd_pkg::SUM_W-1:0]       sum_add;
    logic [prd_pkg::SAMPLE_W-1:0]    min_upd, max_upd;
    logic                            accept, last;

    assign s_ready = job_ready;
    assign accept  = s_valid && s_ready;
    assign last    = (count_reg == prd_pkg::GROUP_CNT_W'(prd_pkg::GROUP_LEN - 1));

    assign sum_add = sum_reg + prd_pkg::SUM_W'(s_data.sample);
    assign min_upd = (s_data.sample < min_reg) ? s_data.sample : min_reg;
    assign max_upd = (s_data.sample > max_reg) ? s_data.sample : max_reg;

    assign job_valid        = accept && last;
    assign job_data.sum     = sum_add;
    assign job_data.min     = min_upd;
    assign job_data.max     = max_upd;
    assign job_data.time_ms = s_data.time_ms;

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (accept) begin
            if (last) begin
                count_next = '0;
                sum_next   = '0;
                min_next   = prd_pkg::SAMPLE_MAX;
                max_next   = '0;
            end else begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_add;
                min_next   = min_upd;
                max_next   = max_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= prd_pkg::SAMPLE_MAX;
            max_reg   <= '0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

endmodule

FILE: src/prd_queue.sv
// Short job queue between the front and back ends of the pulse rate detector.
// A register-based FIFO of group jobs. Depends on prd_pkg.
module prd_queue #(
    parameter int DEPTH = prd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  prd_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output prd_pkg::job_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    prd_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push, pop;

    assign wr_ready = (fill_reg != CNT_W'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: src/prd_div.sv
// Restoring divider of the pulse rate detector: 60000 over a 16-bit interval.
// Produces one quotient bit per cycle. Depends on prd_pkg.
module prd_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [prd_pkg::BPM_W-1:0] divisor,
    output logic                      done,
    output logic [prd_pkg::BPM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(prd_pkg::BPM_W);

    logic [prd_pkg::BPM_W-1:0] div_reg;
    logic [prd_pkg::BPM_W-1:0] rem_reg, rem_next;
    logic [prd_pkg::BPM_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [prd_pkg::BPM_W:0]   trial;
    logic [prd_pkg::BPM_W:0]   trial_sub;

    assign trial     = {rem_reg, quot_reg[prd_pkg::BPM_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign done      = done_reg;
    assign quotient  = quot_reg;

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quot_next = prd_pkg::BPM_DIVIDEND;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial_sub[prd_pkg::BPM_W]) begin
                rem_next  = trial_sub[prd_pkg::BPM_W-1:0];
                quot_next = {quot_reg[prd_pkg::BPM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[prd_pkg::BPM_W-1:0];
                quot_next = {quot_reg[prd_pkg::BPM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(prd_pkg::BPM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

FILE: src/prd_back.sv
// Back end of the pulse rate detector: turns each group job into a result.
// Holds the configuration, reading, window threshold and beat edge state.
// Depends on prd_pkg and prd_div.
module prd_back #(
    parameter int WINDOW_LEN = prd_pkg::WINDOW_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [prd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  prd_pkg::job_t                 job_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output prd_pkg::out_t                 m_data
);

    localparam int WCNT_W = $clog2(WINDOW_LEN);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACCEPT = 3'd1;
    localparam logic [2:0] ST_WINDOW = 3'd2;
    localparam logic [2:0] ST_EDGE   = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [prd_pkg::CFG_W-1:0]      offset_reg, span_reg, margin_reg;
    logic [prd_pkg::MEAN_W-1:0]     mean_reg, mean_next;
    logic [prd_pkg::TIME_W-1:0]     time_reg, time_next;
    logic [prd_pkg::SAMPLE_W-1:0]   held_reg, held_next;
    logic [prd_pkg::SAMPLE_W-1:0]   peak_reg, peak_next;
    logic [WCNT_W-1:0]              wcnt_reg, wcnt_next;
    logic [prd_pkg::SUM_W-1:0]      thresh_reg, thresh_next;
    logic                           prev_reg, prev_next;
    logic                           phase_reg, phase_next;
    logic [prd_pkg::TIME_W-1:0]     start_reg, start_next;
    logic                           level_reg, level_next;
    logic                           bpmv_reg, bpmv_next;
    logic                           m_valid_reg, m_valid_next;
    prd_pkg::out_t                  m_data_reg, m_data_next;

    logic [prd_pkg::SUM_W-1:0]      trimmed;
    logic [prd_pkg::SUM_W-1:0]      diff;
    logic [prd_pkg::SAMPLE_W-1:0]   peak_upd;
    logic                           level;
    logic [prd_pkg::TIME_W-1:0]     interval;
    logic                           div_start;
    logic                           div_done;
    logic [prd_pkg::BPM_W-1:0]      div_quot;

    prd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (interval),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign job_ready = (state_reg == ST_IDLE);

    assign trimmed  = job_data.sum - prd_pkg::SUM_W'(job_data.min)
                      - prd_pkg::SUM_W'(job_data.max);
    assign diff     = prd_pkg::SUM_W'(mean_reg) - prd_pkg::SUM_W'(offset_reg);
    assign peak_upd = (held_reg > peak_reg) ? held_reg : peak_reg;
    assign level    = (prd_pkg::SUM_W'(held_reg) > thresh_reg);
    assign interval = time_reg - start_reg;

    always_comb begin
        state_next   = state_reg;
        mean_next    = mean_reg;
        time_next    = time_reg;
        held_next    = held_reg;
        peak_next    = peak_reg;
        wcnt_next    = wcnt_reg;
        thresh_next  = thresh_reg;
        prev_next    = prev_reg;
        phase_next   = phase_reg;
        start_next   = start_reg;
        level_next   = level_reg;
        bpmv_next    = bpmv_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    mean_next  = trimmed[prd_pkg::SUM_W-1:3];
                    time_next  = job_data.time_ms;
                    state_next = ST_ACCEPT;
                end
            end
            ST_ACCEPT: begin
                if (diff < prd_pkg::SUM_W'(span_reg)) begin
                    held_next = diff[prd_pkg::SAMPLE_W-1:0];
                end
                state_next = ST_WINDOW;
            end
            ST_WINDOW: begin
                if (wcnt_reg == WCNT_W'(WINDOW_LEN - 1)) begin
                    thresh_next = prd_pkg::SUM_W'(peak_upd) - prd_pkg::SUM_W'(margin_reg);
                    peak_next   = '0;
                    wcnt_next   = '0;
                end else begin
                    peak_next = peak_upd;
                    wcnt_next = wcnt_reg + 1'b1;
                end
                state_next = ST_EDGE;
            end
            ST_EDGE: begin
                level_next = level;
                prev_next  = level;
                bpmv_next  = 1'b0;
                state_next = ST_OUT;
                if (!prev_reg && level) begin
                    phase_next = ~phase_reg;
                    if (!phase_reg) begin
                        start_next = time_reg;
                    end else if (interval != '0) begin
                        bpmv_next  = 1'b1;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.reading     = held_reg;
                    m_data_next.above_level = level_reg;
                    m_data_next.bpm_valid   = bpmv_reg;
                    m_data_next.bpm         = bpmv_reg ? div_quot : '0;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mean_reg   <= mean_next;
        time_reg   <= time_next;
        level_reg  <= level_next;
        bpmv_reg   <= bpmv_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            offset_reg  <= prd_pkg::BASELINE_OFFSET_RST;
            span_reg    <= prd_pkg::ACCEPT_SPAN_RST;
            margin_reg  <= prd_pkg::THRESHOLD_MARGIN_RST;
            held_reg    <= '0;
            peak_reg    <= '0;
            wcnt_reg    <= '0;
            thresh_reg  <= '0;
            prev_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            peak_reg    <= peak_next;
            wcnt_reg    <= wcnt_next;
            thresh_reg  <= thresh_next;
            prev_reg    <= prev_next;
            phase_reg   <= phase_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    prd_pkg::REG_BASELINE_OFFSET:  offset_reg <= cfg_wdata;
                    prd_pkg::REG_ACCEPT_SPAN:      span_reg   <= cfg_wdata;
                    prd_pkg::REG_THRESHOLD_MARGIN: margin_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: tb/pulse_rate_detector_test.sv
// Self-checking testbench for pulse_rate_detector: directed sample extremes, beat timing and
// register cases, then randomised pulse trains under handshake idling and back-pressure.
// Depends on prd_pkg and the pulse_rate_detector RTL.
module pulse_rate_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_GROUPS   = prd_pkg::WINDOW_LEN_DEF;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 200000;
    localparam logic [prd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [prd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [prd_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    prd_pkg::in_t                  s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    prd_pkg::out_t                 m_data;

    // Predicted state of the detector and its registers.
    logic [prd_pkg::CFG_W-1:0]       cfg_offset   = prd_pkg::BASELINE_OFFSET_RST;
    logic [prd_pkg::CFG_W-1:0]       cfg_span     = prd_pkg::ACCEPT_SPAN_RST;
    logic [prd_pkg::CFG_W-1:0]       cfg_margin   = prd_pkg::THRESHOLD_MARGIN_RST;
    logic [prd_pkg::GROUP_CNT_W-1:0] acc_count    = '0;
    logic [prd_pkg::SUM_W-1:0]       acc_sum      = '0;
    logic [prd_pkg::SAMPLE_W-1:0]    acc_min      = prd_pkg::SAMPLE_MAX;
    logic [prd_pkg::SAMPLE_W-1:0]    acc_max      = '0;
    logic [prd_pkg::SAMPLE_W-1:0]    reading_hold = '0;
    logic [7:0]                      win_count    = '0;
    logic [prd_pkg::SAMPLE_W-1:0]    win_peak     = '0;
    logic [prd_pkg::SUM_W-1:0]       threshold    = '0;
    logic                            level_prev   = 1'b0;
    logic                            phase_odd    = 1'b0;
    logic [prd_pkg::TIME_W-1:0]      beat_start   = '0;

    prd_pkg::out_t              expected_results[$];
    prd_pkg::out_t              oldest_result;
    logic [prd_pkg::TIME_W-1:0] clock_ms        = '0;
    bit                         sender_pauses   = 1'b1;
    bit                         receiver_stalls = 1'b1;
    int                         hold_left       = 0;
    int                         error_count     = 0;
    int                         samples_sent    = 0;
    int                         results_seen    = 0;
    int                         beats_seen      = 0;
    int                         settings_used   = 0;

    pulse_rate_detector #(
        .WINDOW_LEN(WINDOW_GROUPS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic predict_sample(input prd_pkg::in_t item);
        logic [prd_pkg::SUM_W-1:0] trimmed;
        logic [prd_pkg::SUM_W-1:0] offset_diff;
        logic [prd_pkg::SUM_W-1:0] gap_ms;
        logic                      level_now;
        prd_pkg::out_t             outcome;
        acc_sum = acc_sum + prd_pkg::SUM_W'(item.sample);
        if (item.sample < acc_min) acc_min = item.sample;
        if (item.sample > acc_max) acc_max = item.sample;
        acc_count = acc_count + 1'b1;
        if (acc_count < prd_pkg::GROUP_LEN) return;

        trimmed = acc_sum - prd_pkg::SUM_W'(acc_min) - prd_pkg::SUM_W'(acc_max);
        trimmed = trimmed >> 3;
        acc_count = '0;
        acc_sum   = '0;
        acc_min   = prd_pkg::SAMPLE_MAX;
        acc_max   = '0;

        // A mean below the offset wraps to a large value and fails the span test.
        offset_diff = trimmed - prd_pkg::SUM_W'(cfg_offset);
        if (offset_diff < prd_pkg::SUM_W'(cfg_span)) begin
            reading_hold = offset_diff[prd_pkg::SAMPLE_W-1:0];
        end
        if (reading_hold > win_peak) win_peak = reading_hold;
        win_count = win_count + 1'b1;
        if (win_count >= WINDOW_GROUPS) begin
            threshold = prd_pkg::SUM_W'(win_peak) - prd_pkg::SUM_W'(cfg_margin);
            win_peak  = '0;
            win_count = '0;
        end

        level_now           = prd_pkg::SUM_W'(reading_hold) > threshold;
        outcome.reading     = reading_hold;
        outcome.above_level = level_now;
        outcome.bpm_valid   = 1'b0;
        outcome.bpm         = '0;
        if (!level_prev && level_now) begin
            phase_odd = ~phase_odd;
            if (phase_odd) begin
                beat_start = item.time_ms;
            end else begin
                gap_ms = item.time_ms - beat_start;
                if (gap_ms != 0) begin
                    outcome.bpm_valid = 1'b1;
                    outcome.bpm       = prd_pkg::BPM_DIVIDEND / gap_ms;
                end
            end
        end
        level_prev = level_now;
        expected_results.push_back(outcome);
    endtask

    task automatic send_sample(input logic [prd_pkg::SAMPLE_W-1:0] value,
                               input logic [prd_pkg::TIME_W-1:0] stamp);
        prd_pkg::in_t item;
        item.sample  = value;
        item.time_ms = stamp;
        if (sender_pauses) begin
            while ($urandom_range(99) < 25) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict_sample(item);
        samples_sent++;
    endtask

    function automatic logic [prd_pkg::SAMPLE_W-1:0] clamp_sample(input int value);
        if (value < 0) return '0;
        if (value > 4095) return prd_pkg::SAMPLE_MAX;
        return value[prd_pkg::SAMPLE_W-1:0];
    endfunction

    // Ten samples around one level; a step_max of zero keeps the timestamp fixed unless a noisy sample moves it.
    task automatic send_group(input int level, input int spread, input int step_max,
                              input int noise_pct);
        int i;
        int value;
        for (i = 0; i < prd_pkg::GROUP_LEN; i++) begin
            if (step_max > 0) clock_ms += prd_pkg::TIME_W'($urandom_range(step_max, 1));
            if ($urandom_range(99) < noise_pct) begin
                value = $urandom_range(4095);
                if ($urandom_range(3) == 0) clock_ms = prd_pkg::TIME_W'($urandom_range(65535));
            end else begin
                value = level - spread + int'($urandom_range(2 * spread));
            end
            send_sample(clamp_sample(value), clock_ms);
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [prd_pkg::CFG_IDX_W-1:0] index,
                                  input logic [prd_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (index)
            prd_pkg::REG_BASELINE_OFFSET:  cfg_offset = value;
            prd_pkg::REG_ACCEPT_SPAN:      cfg_span   = value;
            prd_pkg::REG_THRESHOLD_MARGIN: cfg_margin = value;
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [prd_pkg::CFG_W-1:0] offset,
                                 input logic [prd_pkg::CFG_W-1:0] span,
                                 input logic [prd_pkg::CFG_W-1:0] margin);
        wait_for_results();
        write_register(prd_pkg::REG_BASELINE_OFFSET, offset);
        write_register(prd_pkg::REG_ACCEPT_SPAN, span);
        write_register(prd_pkg::REG_THRESHOLD_MARGIN, margin);
        settings_used++;
    endtask

    // Periodic pulse trains: a resting level with a peak every few groups, plus broken groups.
    task automatic run_pulse_phase(input logic [prd_pkg::CFG_W-1:0] offset,
                                   input logic [prd_pkg::CFG_W-1:0] span,
                                   input logic [prd_pkg::CFG_W-1:0] margin, input int groups,
                                   input int hold_off);
        int g;
        int period;
        int rest;
        int peak;
        int level;
        set_registers(offset, span, margin);
        hold_left = hold_off;
        for (g = 0; g < groups; g++) begin
            if (g % 12 == 0) begin
                period = $urandom_range(6, 2);
                rest   = $urandom_range(300);
                peak   = rest + int'($urandom_range(600, 50));
            end
            level = int'(offset) + ((g % period == 0) ? peak + int'($urandom_range(8)) : rest);
            if ($urandom_range(99) < 8) level = $urandom_range(4095);
            send_group(level, 12, 8, 4);
        end
    endtask

    task automatic test_unused_register();
        wait_for_results();
        write_register(REG_UNUSED, prd_pkg::SAMPLE_MAX);
    endtask

    task automatic test_sample_extremes();
        int i;
        for (i = 0; i < prd_pkg::GROUP_LEN; i++) begin
            send_sample((i % 2) ? prd_pkg::SAMPLE_MAX : 12'd0, (i % 2) ? 16'hFFFF : 16'h0000);
        end
        clock_ms = 16'hFFFF;
        send_group(4095, 0, 0, 0);
        send_group(0, 0, 0, 0);
    endtask

    // Pairs of rising edges at chosen stamps: a very long interval, a zero interval
    // and an interval of one tick across the timestamp wrap.
    task automatic test_beat_timing();
        set_registers(12'd0, 12'd4095, prd_pkg::THRESHOLD_MARGIN_RST);
        send_group(0, 0, 0, 0);
        clock_ms = 16'd65530;
        send_group(1000, 0, 0, 0);
        send_group(0, 0, 0, 0);
        send_group(1000, 0, 0, 0);
        send_group(0, 0, 0, 0);
        send_group(1000, 0, 0, 0);
        send_group(0, 0, 0, 0);
        clock_ms = 16'hFFFF;
        send_group(1000, 0, 0, 0);
        send_group(0, 0, 0, 0);
        clock_ms = 16'd0;
        send_group(1000, 0, 0, 0);
    endtask

    task automatic test_default_settings();
        run_pulse_phase(prd_pkg::BASELINE_OFFSET_RST, prd_pkg::ACCEPT_SPAN_RST,
                        prd_pkg::THRESHOLD_MARGIN_RST, 20, 0);
    endtask

    task automatic test_full_span_no_pauses();
        sender_pauses   = 1'b0;
        receiver_stalls = 1'b0;
        run_pulse_phase(12'd0, 12'd4095, 12'd0, 20, 0);
        sender_pauses   = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_result_backpressure();
        sender_pauses = 1'b0;
        run_pulse_phase(12'd300, 12'd800, 12'd40, 12, HOLD_OFF_CYCLES);
        sender_pauses = 1'b1;
    endtask

    task automatic test_margin_above_peak();
        run_pulse_phase(12'd800, 12'd2000, 12'd4095, 22, 0);
    endtask

    task automatic test_span_closed();
        run_pulse_phase(12'd4095, 12'd0, 12'd10, 6, 0);
    endtask

    task automatic test_random_settings();
        int k;
        for (k = 0; k < 3; k++) begin
            run_pulse_phase(prd_pkg::CFG_W'($urandom_range(2000)),
                            prd_pkg::CFG_W'($urandom_range(1500, 200)),
                            prd_pkg::CFG_W'($urandom_range(100)), 14, 0);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: result with none expected: reading=%0d above=%0b",
                         $time, m_data.reading, m_data.above_level);
                $display("%0t:           actual bpm_valid=%0b bpm=%0d",
                         $time, m_data.bpm_valid, m_data.bpm);
            end else begin
                oldest_result = expected_results.pop_front();
                results_seen++;
                if (m_data.bpm_valid === 1'b1) beats_seen++;
                if (m_data.reading !== oldest_result.reading ||
                    m_data.above_level !== oldest_result.above_level ||
                    m_data.bpm_valid !== oldest_result.bpm_valid ||
                    m_data.bpm !== oldest_result.bpm) begin
                    error_count++;
                    $display("%0t: mismatch: expected reading=%0d above=%0b bpm_valid=%0b bpm=%0d",
                             $time, oldest_result.reading, oldest_result.above_level,
                             oldest_result.bpm_valid, oldest_result.bpm);
                    $display("%0t:           actual reading=%0d above=%0b bpm_valid=%0b bpm=%0d",
                             $time, m_data.reading, m_data.above_level, m_data.bpm_valid,
                             m_data.bpm);
                end
            end
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (receiver_stalls && $urandom_range(99) < 25) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t: timed out with %0d results outstanding", $time, expected_results.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_unused_register();
        test_sample_extremes();
        test_beat_timing();
        test_default_settings();
        test_full_span_no_pauses();
        test_result_backpressure();
        test_margin_above_peak();
        test_span_closed();
        test_random_settings();
        wait_for_results();
        $display("Run covered %0d sample transfers and %0d result transfers, %0d with a beat rate,",
                 samples_sent, results_seen, beats_seen);
        $display("over %0d register settings; %0d mismatches.", settings_used, error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/prd_pkg.sv
src/prd_front.sv
src/prd_queue.sv
src/prd_div.sv
src/prd_back.sv
src/pulse_rate_detector.sv
tb/pulse_rate_detector_test.sv
